>>> src/lfb_pkg.sv
// ----------------------------------------------------------------------------
// lfb_pkg
// Shared types and constants of the login failure backoff table.
// ----------------------------------------------------------------------------
`default_nettype none

package lfb_pkg;

  localparam int ADDR_W     = 32;
  localparam int NOW_W      = 48;
  localparam int COUNT_W    = 8;
  localparam int BASE_W     = 16;
  localparam int EXP_W      = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [1:0] ACT_CHECK   = 2'd0;
  localparam logic [1:0] ACT_SUCCESS = 2'd1;
  localparam logic [1:0] ACT_FAILURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EXPONENT = 1'd1;

  localparam logic [BASE_W-1:0] BACKOFF_BASE_RST = 16'd500;
  localparam logic [EXP_W-1:0]  MAX_EXPONENT_RST = 5'd13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] peer_ip;
    logic [NOW_W-1:0]  now_ms;
  } req_t;

  typedef struct packed {
    logic banned;
    logic dropped;
  } rsp_t;

endpackage

`default_nettype wire

>>> src/lfb_entry_ram.sv
// ----------------------------------------------------------------------------
// lfb_entry_ram
// Single-port-write, single-port-read entry store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfb_entry_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/login_failure_backoff_table.sv
// ----------------------------------------------------------------------------
// login_failure_backoff_table
// Peer address table with failure counts and exponential lockout windows.
// ----------------------------------------------------------------------------
// One request word is handled at a time. The table entries sit in a RAM with
// one read port, so a request scans the entries one per cycle, then forms the
// elapsed time and window in S_CALC and compares and writes back in S_DONE,
// which waits while a previous result word is still unread. The result sits
// in an output register, so the next request is taken while it waits. Valid
// bits live in flip-flops and are cleared by reset at once; the configuration
// registers are read in S_CALC, so a write during a scan already applies to
// the request in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module login_failure_backoff_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int TIME_BITS     = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire lfb_pkg::req_t                   req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output lfb_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import lfb_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int WIN_W = BASE_W + (1 << EXP_W) - 1;
  localparam int CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

  typedef struct packed {
    logic [ADDR_W-1:0]    address;
    logic [COUNT_W-1:0]   fail_count;
    logic [TIME_BITS-1:0] last_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CALC, S_DONE} state_t;

  state_t               state;
  req_t                 cur;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [BASE_W-1:0]    backoff_base;
  logic [EXP_W-1:0]     max_exp;

  logic [CNT_W-1:0]     issue_cnt;
  logic                 cmp_pending;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 found;
  logic [IDX_W-1:0]     hit_idx;
  logic [COUNT_W-1:0]   hit_cnt;
  logic [TIME_BITS-1:0] hit_time;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [CMP_W-1:0]     elapsed;
  logic [CMP_W-1:0]     window;

  entry_t               rd_entry;
  entry_t               wr_entry;
  logic [ENTRY_W-1:0]   rd_word;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;

  logic [TIME_BITS-1:0] now_t;
  logic [EXP_W-1:0]     exp_sel;
  logic [TIME_BITS-1:0] elapsed_next;
  logic                 issuing;
  logic                 fire;
  logic                 is_failure;
  rsp_t                 rsp_next;

  assign req_ready  = (state == S_IDLE);
  assign issuing    = (issue_cnt != CNT_W'(TABLE_ENTRIES));
  assign fire       = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign is_failure = (cur.action == ACT_FAILURE);
  assign now_t      = TIME_BITS'(cur.now_ms);
  assign rd_entry   = entry_t'(rd_word);

  assign exp_sel      = (hit_cnt > COUNT_W'(max_exp)) ? max_exp : hit_cnt[EXP_W-1:0];
  assign elapsed_next = now_t - hit_time;

  always_comb begin
    rsp_next = '0;
    case (cur.action)
      ACT_CHECK:   rsp_next.banned  = found && (elapsed < window);
      ACT_SUCCESS: rsp_next.banned  = 1'b0;
      ACT_FAILURE: rsp_next.dropped = !found && !free_found;
      default:     rsp_next = '0;
    endcase
  end

  always_comb begin
    wr_entry.address    = cur.peer_ip;
    wr_entry.last_time  = now_t;
    wr_entry.fail_count = '0;
    if (found) begin
      wr_entry.fail_count = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + COUNT_W'(1);
    end
    wr_en   = fire && is_failure && (found || free_found);
    wr_addr = found ? hit_idx : free_idx;
  end

  lfb_entry_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_entry)),
    .rd_addr (issue_cnt[IDX_W-1:0]),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_base <= BACKOFF_BASE_RST;
      max_exp      <= MAX_EXPONENT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BACKOFF_BASE: backoff_base <= cfg_data;
        REG_MAX_EXPONENT: max_exp      <= cfg_data[EXP_W-1:0];
        default:          backoff_base <= backoff_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      entry_valid <= '0;
      issue_cnt   <= '0;
      cmp_pending <= 1'b0;
      found       <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !fire) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur         <= req;
            issue_cnt   <= '0;
            cmp_pending <= 1'b0;
            found       <= 1'b0;
            free_found  <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_pending <= issuing;
          cmp_idx     <= issue_cnt[IDX_W-1:0];
          if (issuing) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          if (cmp_pending) begin
            if (entry_valid[cmp_idx]) begin
              if (!found && rd_entry.address == cur.peer_ip) begin
                found    <= 1'b1;
                hit_idx  <= cmp_idx;
                hit_cnt  <= rd_entry.fail_count;
                hit_time <= rd_entry.last_time;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (cmp_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          elapsed <= CMP_W'(elapsed_next);
          window  <= CMP_W'(CMP_W'(backoff_base) << exp_sel);
          state   <= S_DONE;
        end
        S_DONE: begin
          if (fire) begin
            rsp_valid <= 1'b1;
            rsp       <= rsp_next;
            if (cur.action == ACT_SUCCESS && found) begin
              entry_valid[hit_idx] <= 1'b0;
            end
            if (is_failure && !found && free_found) begin
              entry_valid[free_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result only ever appears from the write-back state
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside write-back");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.banned && rsp.dropped))
    else $error("banned and dropped both set");

  // a drop needs every entry in use
  assert property (@(posedge clk) disable iff (rst)
    (fire && rsp_next.dropped) |-> (&entry_valid))
    else $error("insert dropped with a free entry");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cmp_pending) |-> (cmp_idx != IDX_W'(TABLE_ENTRIES - 1)) || !issuing)
    else $error("scan still issuing at last compare");

endmodule

`default_nettype wire

>>> tb/tb_login_failure_backoff_table.sv
// ----------------------------------------------------------------------------
// tb_login_failure_backoff_table
// Self-checking bench for the login failure backoff table.
// ----------------------------------------------------------------------------
// Request words go in over valid/ready with random gaps. A scoreboard class
// keeps its own copy of the address table and registers. It predicts banned
// and dropped for every accepted request and checks each result word in
// order. The run opens with directed cases: window edges, time wrap, removal,
// the unused action, a full table and reuse of a freed entry. Random phases
// follow under several register settings, including a zero base, a doubling
// cap of 31 and a burst that drives one count past saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_login_failure_backoff_table;
  import lfb_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int POOL_SIZE      = 24;
  localparam int QUIET_CYCLES   = 30;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_PRINTED    = 40;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  class backoff_scoreboard;
    logic [BASE_W-1:0]  base_ms;
    logic [EXP_W-1:0]   max_exp;
    bit                 in_use [ENTRIES];
    logic [ADDR_W-1:0]  peer [ENTRIES];
    logic [COUNT_W-1:0] fail_count [ENTRIES];
    logic [NOW_W-1:0]   last_fail [ENTRIES];
    rsp_t               verdicts [$];
    int                 errors;
    int                 requests;
    int                 checked;
    int                 banned_seen;
    int                 dropped_seen;

    function new();
      base_ms = BACKOFF_BASE_RST;
      max_exp = MAX_EXPONENT_RST;
      foreach (in_use[i]) in_use[i] = 1'b0;
      errors = 0;
      requests = 0;
      checked = 0;
      banned_seen = 0;
      dropped_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_BACKOFF_BASE) begin
        base_ms = data[BASE_W-1:0];
      end else if (idx == REG_MAX_EXPONENT) begin
        max_exp = data[EXP_W-1:0];
      end
    endfunction

    function int lookup(logic [ADDR_W-1:0] ip);
      for (int i = 0; i < ENTRIES; i++) begin
        if (in_use[i] && peer[i] == ip) return i;
      end
      return -1;
    endfunction

    // Applies one accepted request to the table copy and queues its verdict.
    function void log_attempt(req_t r);
      rsp_t             v;
      int               hit;
      int               slot;
      int               shift;
      logic [NOW_W-1:0] elapsed;
      logic [63:0]      window;
      v = '0;
      hit = lookup(r.peer_ip);
      slot = -1;
      requests++;
      case (r.action)
        ACT_CHECK: begin
          if (hit >= 0) begin
            shift = (fail_count[hit] > max_exp) ? int'(max_exp) : int'(fail_count[hit]);
            elapsed = r.now_ms - last_fail[hit];
            window = 64'(base_ms) << shift;
            v.banned = (64'(elapsed) < window);
          end
        end
        ACT_SUCCESS: begin
          if (hit >= 0) in_use[hit] = 1'b0;
        end
        ACT_FAILURE: begin
          if (hit >= 0) begin
            if (fail_count[hit] != COUNT_MAX) fail_count[hit]++;
            last_fail[hit] = r.now_ms;
          end else begin
            for (int i = 0; i < ENTRIES && slot < 0; i++) begin
              if (!in_use[i]) slot = i;
            end
            if (slot >= 0) begin
              in_use[slot] = 1'b1;
              peer[slot] = r.peer_ip;
              fail_count[slot] = '0;
              last_fail[slot] = r.now_ms;
            end else begin
              v.dropped = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      verdicts = {verdicts, v};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR: %s", msg);
    endtask

    task check_verdict(rsp_t got);
      rsp_t want;
      if (verdicts.size() == 0) begin
        report($sformatf("result word with nothing expected: banned %0b dropped %0b",
                         got.banned, got.dropped));
      end else begin
        want = verdicts.pop_front();
        checked++;
        if (want.banned) banned_seen++;
        if (want.dropped) dropped_seen++;
        if (got.banned !== want.banned)
          report($sformatf("word %0d: banned %0b, expected %0b",
                           checked, got.banned, want.banned));
        if (got.dropped !== want.dropped)
          report($sformatf("word %0d: dropped %0b, expected %0b",
                           checked, got.dropped, want.dropped));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit                    steady = 1'b0;
  int                    cycles = 0;
  logic [ADDR_W-1:0]     pool [POOL_SIZE];
  logic [NOW_W-1:0]      clock_ms;
  backoff_scoreboard     sb;

  login_failure_backoff_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) sb.check_verdict(rsp);
      rsp_ready <= steady || ($urandom_range(0, 99) >= 37);
    end
  end

  task automatic send_attempt(input logic [1:0] act, input logic [ADDR_W-1:0] ip,
                              input logic [NOW_W-1:0] t);
    req_t w;
    w.action = act;
    w.peer_ip = ip;
    w.now_ms = t;
    if (!steady && $urandom_range(0, 99) < 37) begin
      req_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(0, 99) < 37);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
    sb.log_attempt(w);
  endtask

  task automatic tick_clock();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
    end else if (pick < 65) begin
      clock_ms += $urandom_range(1, 700);
    end else if (pick < 93) begin
      clock_ms += $urandom_range(1, 1 << $urandom_range(10, 23));
    end else begin
      clock_ms = NOW_W'({$urandom, $urandom});
    end
  endtask

  // Inserts only come from the address pool so that stale peers cannot clog
  // the table; unknown peers still show up in checks and removals.
  task automatic random_attempt();
    logic [1:0]        act;
    logic [ADDR_W-1:0] ip;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) act = ACT_CHECK;
    else if (pick < 75) act = ACT_FAILURE;
    else if (pick < 95) act = ACT_SUCCESS;
    else act = ACT_UNUSED;
    ip = pool[$urandom_range(0, POOL_SIZE - 1)];
    if (act != ACT_FAILURE && $urandom_range(0, 9) == 0) ip = $urandom;
    tick_clock();
    send_attempt(act, ip, clock_ms);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Upper data bits above the exponent field are junk and must be ignored.
  task automatic set_config(input logic [BASE_W-1:0] base, input logic [EXP_W-1:0] cap);
    logic [CFG_DATA_W-1:0] exp_word;
    exp_word = CFG_DATA_W'($urandom);
    exp_word[EXP_W-1:0] = cap;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_BACKOFF_BASE;
    cfg_data <= base;
    @(posedge clk);
    sb.write_reg(REG_BACKOFF_BASE, base);
    cfg_index <= REG_MAX_EXPONENT;
    cfg_data <= exp_word;
    @(posedge clk);
    sb.write_reg(REG_MAX_EXPONENT, exp_word);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] hot;
    sb = new();
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values
    send_attempt(ACT_CHECK, '0, '0);
    send_attempt(ACT_FAILURE, '0, '0);
    send_attempt(ACT_CHECK, '0, 48'd499);
    send_attempt(ACT_CHECK, '0, 48'd500);
    send_attempt(ACT_FAILURE, '1, '1);
    send_attempt(ACT_CHECK, '1, 48'd498);
    send_attempt(ACT_FAILURE, '0, 48'd1000);
    send_attempt(ACT_CHECK, '0, 48'd1999);
    send_attempt(ACT_SUCCESS, '0, 48'd2000);
    send_attempt(ACT_CHECK, '0, 48'd2001);
    send_attempt(ACT_UNUSED, '1, '1);
    send_attempt(ACT_CHECK, '1, 48'd100);
    // fill the table, overflow it, then reuse a freed entry
    for (int i = 2; i <= ENTRIES; i++) send_attempt(ACT_FAILURE, pool[i], 48'd3000);
    send_attempt(ACT_FAILURE, pool[ENTRIES + 1], 48'd3001);
    send_attempt(ACT_SUCCESS, pool[8], 48'd3002);
    send_attempt(ACT_FAILURE, pool[ENTRIES + 1], 48'd3003);

    clock_ms = 48'd5000;
    repeat (150) random_attempt();

    settle();
    set_config(16'd1, 5'd0);
    repeat (120) random_attempt();

    settle();
    set_config(16'hFFFF, 5'd31);
    steady <= 1'b1;
    repeat (120) random_attempt();

    settle();
    steady <= 1'b0;
    set_config(16'd0, 5'd20);
    repeat (100) random_attempt();

    // one peer hammered well past count saturation
    settle();
    set_config(BACKOFF_BASE_RST, MAX_EXPONENT_RST);
    foreach (pool[i]) send_attempt(ACT_SUCCESS, pool[i], clock_ms);
    hot = pool[2];
    for (int n = 0; n < 270; n++) begin
      clock_ms += $urandom_range(1, 50);
      send_attempt(ACT_FAILURE, hot, clock_ms);
      if (n % 16 == 15) send_attempt(ACT_CHECK, hot, clock_ms + $urandom_range(1, 6000000));
    end
    repeat (8) send_attempt(ACT_CHECK, hot, clock_ms + $urandom_range(1, 6000000));

    settle();
    set_config(BASE_W'($urandom_range(1, 4000)), EXP_W'($urandom_range(0, 31)));
    repeat (100) random_attempt();

    settle();
    $display("tb: %0d requests, %0d result words checked, %0d banned, %0d dropped",
             sb.requests, sb.checked, sb.banned_seen, sb.dropped_seen);
    $display("tb: six register settings incl. zero base, cap 31 and count saturation");
    if (sb.verdicts.size() != 0) sb.report("result words still outstanding at end of run");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
